// ===== design/rgbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbcs_pkg
// Shared widths, codes and types for the RGB channel statistics block.
// ----------------------------------------------------------------------------
package rgbcs_pkg;

    localparam int NCHAN      = 3;
    localparam int VAL_W      = 16;
    localparam int MEAN_W     = 24;
    localparam int DEV_W      = 24;
    localparam int SQ_W       = 2 * DEV_W;
    localparam int SUM_W      = 40;
    localparam int SQSUM_W    = 64;
    localparam int PCOUNT_W   = 24;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 168;

    localparam int COUNT_BITS_DEFAULT = 24;

    // Fractional bits of the 16.8 mean
    localparam int MEAN_FRAC = MEAN_W - VAL_W;

    typedef logic [1:0] chan_t;
    localparam chan_t CH_RED   = 2'd0;
    localparam chan_t CH_GREEN = 2'd1;
    localparam chan_t CH_BLUE  = 2'd2;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
    localparam cfg_addr_t REG_MODE       = 2'd0;
    localparam cfg_addr_t REG_RED_MEAN   = 2'd1;
    localparam cfg_addr_t REG_GREEN_MEAN = 2'd2;
    localparam cfg_addr_t REG_BLUE_MEAN  = 2'd3;

    localparam logic MODE_TOTALS    = 1'b0;
    localparam logic MODE_DEVIATION = 1'b1;

    // Load strobes for the lane pipeline registers
    typedef struct packed {
        logic ld_in;
        logic ld_dev;
        logic ld_sq;
    } lane_ctl_t;

    // Per-channel accumulated statistics
    typedef struct packed {
        logic [SUM_W-1:0]   total;
        logic [VAL_W-1:0]   minimum;
        logic [VAL_W-1:0]   maximum;
        logic [SQSUM_W-1:0] sq_total;
    } chan_stats_t;

endpackage

// ===== design/rgb_channel_statistics.sv =====
// ----------------------------------------------------------------------------
// rgb_channel_statistics
// Two-pass per-channel colour statistics over a stream of RGB points.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one point per request, tdata = red, green, blue.
//   Output stream m_*: three result requests per point (red, green, blue),
//   tlast marks the blue one, tuser carries the channel code.
//   Config port: write accumulate_mode and the three 16.8 means while idle.
// Path: an accepted point passes the input reg, deviation reg and square reg,
//   then the state update, before its red result is presented.
// Output rate: set by the output channel, which sends the three channel
//   results of one point one per cycle while m_tready is high.
//   Three more points can sit in the lane pipeline behind a waiting result.
// Reset: aresetn low clears the statistics, count, overflow flag, the config
//   registers and all valid flags; next point seeds min/max/total or sq_total.
// Stall: while m_tready is low the current result holds; the statistics
//   update for the next point waits until the blue result is taken, and the
//   pipeline fills and then drops s_tready.
// ----------------------------------------------------------------------------
module rgb_channel_statistics #(
    parameter int COUNT_BITS = rgbcs_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // config write port
    input  logic                             cfg_wr_en,
    input  logic [rgbcs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [rgbcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // point input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata from bit 0: red_value[16], green_value[16], blue_value[16]
    input  logic [rgbcs_pkg::IN_DATA_W-1:0]  s_tdata,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata from bit 0: channel_total[40], channel_minimum[16],
    //   channel_maximum[16], squared_deviation_total[64], point_count[24],
    //   count_overflow[1], zero pad[7]
    output logic [rgbcs_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: channel[2]
    output logic [1:0]                       m_tuser,
    output logic                             m_tlast
);

    localparam int NCHAN = rgbcs_pkg::NCHAN;
    localparam int VAL_W = rgbcs_pkg::VAL_W;

    // config registers
    logic                           mode_reg;
    logic [rgbcs_pkg::MEAN_W-1:0]   mean_reg [NCHAN];

    // pipeline valid flags
    logic v0_reg, v1_reg, v2_reg;
    logic rdy0, rdy1, rdy2;

    // output sequencer
    logic             out_busy_reg;
    rgbcs_pkg::chan_t out_idx_reg;
    logic             out_free;
    logic             update;

    rgbcs_pkg::lane_ctl_t   ctl;
    logic [VAL_W-1:0]             lane_val [NCHAN];
    logic [rgbcs_pkg::SQ_W-1:0]   lane_sq  [NCHAN];
    rgbcs_pkg::chan_stats_t       stats    [NCHAN];
    rgbcs_pkg::chan_stats_t       sel;
    logic [COUNT_BITS-1:0]        count;
    logic                         overflow;

    // --- config writes ---
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= rgbcs_pkg::MODE_TOTALS;
            for (int c = 0; c < NCHAN; c++) begin
                mean_reg[c] <= '0;
            end
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                rgbcs_pkg::REG_MODE:       mode_reg    <= cfg_wdata[0];
                rgbcs_pkg::REG_RED_MEAN:   mean_reg[0] <= cfg_wdata;
                rgbcs_pkg::REG_GREEN_MEAN: mean_reg[1] <= cfg_wdata;
                rgbcs_pkg::REG_BLUE_MEAN:  mean_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // --- pipeline flow control ---
    // state update fires once the previous point's blue result leaves
    assign out_free = !out_busy_reg || (m_tready && (out_idx_reg == rgbcs_pkg::CH_BLUE));
    assign update   = v2_reg && out_free;
    assign rdy2     = !v2_reg || out_free;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;

    assign ctl.ld_in  = s_tvalid && rdy0;
    assign ctl.ld_dev = v0_reg && rdy1;
    assign ctl.ld_sq  = v1_reg && rdy2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy0) begin
                v0_reg <= s_tvalid;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // --- colour lanes ---
    for (genvar c = 0; c < NCHAN; c++) begin : g_lane
        rgbcs_lane u_lane (
            .aclk      (aclk),
            .ctl       (ctl),
            .value_in  (s_tdata[c*VAL_W +: VAL_W]),
            .mean      (mean_reg[c]),
            .value_out (lane_val[c]),
            .sq_out    (lane_sq[c])
        );
    end

    // --- statistics state ---
    rgbcs_accum #(
        .COUNT_BITS (COUNT_BITS)
    ) u_accum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .update   (update),
        .mode     (mode_reg),
        .value    (lane_val),
        .sq       (lane_sq),
        .stats    (stats),
        .count    (count),
        .overflow (overflow)
    );

    // --- output sequencer: red, green, blue from the live state ---
    // state only changes when the last result has been taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_busy_reg <= 1'b0;
            out_idx_reg  <= rgbcs_pkg::CH_RED;
        end else if (update) begin
            out_busy_reg <= 1'b1;
            out_idx_reg  <= rgbcs_pkg::CH_RED;
        end else if (out_busy_reg && m_tready) begin
            case (out_idx_reg)
                rgbcs_pkg::CH_RED:   out_idx_reg  <= rgbcs_pkg::CH_GREEN;
                rgbcs_pkg::CH_GREEN: out_idx_reg  <= rgbcs_pkg::CH_BLUE;
                default:             out_busy_reg <= 1'b0;
            endcase
        end
    end

    always_comb begin
        case (out_idx_reg)
            rgbcs_pkg::CH_RED:   sel = stats[0];
            rgbcs_pkg::CH_GREEN: sel = stats[1];
            default:             sel = stats[2];
        endcase
    end

    assign m_tvalid = out_busy_reg;
    assign m_tuser  = out_idx_reg;
    assign m_tlast  = (out_idx_reg == rgbcs_pkg::CH_BLUE);
    assign m_tdata  = {7'd0, overflow, rgbcs_pkg::PCOUNT_W'(count),
                       sel.sq_total, sel.maximum, sel.minimum, sel.total};

endmodule

// ===== design/rgbcs_lane.sv =====
// ----------------------------------------------------------------------------
// rgbcs_lane
// One colour lane: input register, |value - mean| stage, squaring stage.
// ----------------------------------------------------------------------------
module rgbcs_lane (
    input  logic                         aclk,
    input  rgbcs_pkg::lane_ctl_t         ctl,
    input  logic [rgbcs_pkg::VAL_W-1:0]  value_in,
    input  logic [rgbcs_pkg::MEAN_W-1:0] mean,
    output logic [rgbcs_pkg::VAL_W-1:0]  value_out,
    output logic [rgbcs_pkg::SQ_W-1:0]   sq_out
);

    logic [rgbcs_pkg::VAL_W-1:0]  val0_reg;
    logic [rgbcs_pkg::VAL_W-1:0]  val1_reg;
    logic [rgbcs_pkg::VAL_W-1:0]  val2_reg;
    logic [rgbcs_pkg::DEV_W-1:0]  dev1_reg;
    logic [rgbcs_pkg::DEV_W-1:0]  dev1_next;
    logic [rgbcs_pkg::SQ_W-1:0]   sq2_reg;
    logic [rgbcs_pkg::MEAN_W-1:0] scaled;

    // value in 16.8 form, then absolute difference
    always_comb begin
        scaled = {val0_reg, {rgbcs_pkg::MEAN_FRAC{1'b0}}};
        if (scaled >= mean) begin
            dev1_next = scaled - mean;
        end else begin
            dev1_next = mean - scaled;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ld_in) begin
            val0_reg <= value_in;
        end
        if (ctl.ld_dev) begin
            val1_reg <= val0_reg;
            dev1_reg <= dev1_next;
        end
        if (ctl.ld_sq) begin
            val2_reg <= val1_reg;
            sq2_reg  <= rgbcs_pkg::SQ_W'(dev1_reg) * rgbcs_pkg::SQ_W'(dev1_reg);
        end
    end

    assign value_out = val2_reg;
    assign sq_out    = sq2_reg;

endmodule

// ===== design/rgbcs_accum.sv =====
// ----------------------------------------------------------------------------
// rgbcs_accum
// Statistics state: totals, extremes, squared sums, point count, overflow.
// ----------------------------------------------------------------------------
module rgbcs_accum #(
    parameter int COUNT_BITS = rgbcs_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        update,
    input  logic                        mode,
    input  logic [rgbcs_pkg::VAL_W-1:0] value [rgbcs_pkg::NCHAN],
    input  logic [rgbcs_pkg::SQ_W-1:0]  sq    [rgbcs_pkg::NCHAN],
    output rgbcs_pkg::chan_stats_t      stats [rgbcs_pkg::NCHAN],
    output logic [COUNT_BITS-1:0]       count,
    output logic                        overflow
);

    localparam int SUM_W   = rgbcs_pkg::SUM_W;
    localparam int SQSUM_W = rgbcs_pkg::SQSUM_W;

    rgbcs_pkg::chan_stats_t stats_reg  [rgbcs_pkg::NCHAN];
    rgbcs_pkg::chan_stats_t stats_next [rgbcs_pkg::NCHAN];
    logic                   first_reg;
    logic                   first_next;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic [SUM_W:0]         tot_sum   [rgbcs_pkg::NCHAN];
    logic [SQSUM_W:0]       sq_sum    [rgbcs_pkg::NCHAN];

    always_comb begin
        ovf_next   = ovf_reg;
        first_next = first_reg;
        count_next = count_reg;
        for (int c = 0; c < rgbcs_pkg::NCHAN; c++) begin
            stats_next[c] = stats_reg[c];
            tot_sum[c] = {1'b0, stats_reg[c].total}
                       + {{(SUM_W + 1 - rgbcs_pkg::VAL_W){1'b0}}, value[c]};
            sq_sum[c]  = {1'b0, stats_reg[c].sq_total}
                       + {{(SQSUM_W + 1 - rgbcs_pkg::SQ_W){1'b0}}, sq[c]};
        end
        if (update) begin
            first_next = 1'b0;
            for (int c = 0; c < rgbcs_pkg::NCHAN; c++) begin
                if (mode == rgbcs_pkg::MODE_TOTALS) begin
                    if (first_reg) begin
                        stats_next[c].total   = {{(SUM_W - rgbcs_pkg::VAL_W){1'b0}}, value[c]};
                        stats_next[c].minimum = value[c];
                        stats_next[c].maximum = value[c];
                    end else begin
                        if (tot_sum[c][SUM_W]) begin
                            stats_next[c].total = '1;
                            ovf_next = 1'b1;
                        end else begin
                            stats_next[c].total = tot_sum[c][SUM_W-1:0];
                        end
                        if (value[c] < stats_reg[c].minimum) begin
                            stats_next[c].minimum = value[c];
                        end else if (value[c] > stats_reg[c].maximum) begin
                            stats_next[c].maximum = value[c];
                        end
                    end
                end else begin
                    if (first_reg) begin
                        stats_next[c].sq_total = {{(SQSUM_W - rgbcs_pkg::SQ_W){1'b0}}, sq[c]};
                    end else if (sq_sum[c][SQSUM_W]) begin
                        stats_next[c].sq_total = '1;
                        ovf_next = 1'b1;
                    end else begin
                        stats_next[c].sq_total = sq_sum[c][SQSUM_W-1:0];
                    end
                end
            end
            // count holds at all ones; a point arriving there flags overflow
            if (&count_reg) begin
                ovf_next = 1'b1;
            end else begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 1'b1;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            for (int c = 0; c < rgbcs_pkg::NCHAN; c++) begin
                stats_reg[c] <= '0;
            end
        end else begin
            first_reg <= first_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            for (int c = 0; c < rgbcs_pkg::NCHAN; c++) begin
                stats_reg[c] <= stats_next[c];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < rgbcs_pkg::NCHAN; c++) begin
            stats[c] = stats_reg[c];
        end
    end

    assign count    = count_reg;
    assign overflow = ovf_reg;

endmodule

// ===== tb/tb_rgb_channel_statistics.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rgb_channel_statistics
// Self-checking bench for the two-pass RGB channel statistics block.
// Points are fed from a queue by a clocked driver. Every accepted point runs
// through a local model of the per-channel totals, min/max, squared
// deviations, count and overflow flag. That model queues the three expected
// results, and a clocked monitor compares them with the output stream.
// Phases vary the mode, the means and the idling on both sides. They also
// include one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_rgb_channel_statistics;

    localparam int NCHAN      = rgbcs_pkg::NCHAN;
    localparam int VAL_W      = rgbcs_pkg::VAL_W;
    localparam int MEAN_W     = rgbcs_pkg::MEAN_W;
    localparam int MEAN_FRAC  = rgbcs_pkg::MEAN_FRAC;
    localparam int DEV_W      = rgbcs_pkg::DEV_W;
    localparam int SQ_W       = rgbcs_pkg::SQ_W;
    localparam int SUM_W      = rgbcs_pkg::SUM_W;
    localparam int SQSUM_W    = rgbcs_pkg::SQSUM_W;
    localparam int PCOUNT_W   = rgbcs_pkg::PCOUNT_W;
    localparam int CFG_ADDR_W = rgbcs_pkg::CFG_ADDR_W;
    localparam int CFG_DATA_W = rgbcs_pkg::CFG_DATA_W;
    localparam int IN_DATA_W  = rgbcs_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = rgbcs_pkg::OUT_DATA_W;

    // Point counter at its default width
    localparam int TB_COUNT_BITS = rgbcs_pkg::COUNT_BITS_DEFAULT;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << TB_COUNT_BITS) - 1;

    localparam logic [SUM_W-1:0]   TOTAL_MAX = {SUM_W{1'b1}};
    localparam logic [SQSUM_W-1:0] SQ_MAX    = {SQSUM_W{1'b1}};

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 8;     // a bit over the pipeline latency
    localparam int STUCK_LIMIT  = 4000;  // cycles with no request moving
    localparam int LONG_HOLD    = 500;   // receiver hold-off under pressure
    localparam int RANDOM_ITEMS = 33;    // per idling phase

    localparam rgbcs_pkg::chan_t CHAN_CODE [NCHAN] =
        '{rgbcs_pkg::CH_RED, rgbcs_pkg::CH_GREEN, rgbcs_pkg::CH_BLUE};

    typedef struct {
        logic [VAL_W-1:0] red;
        logic [VAL_W-1:0] green;
        logic [VAL_W-1:0] blue;
    } point_t;

    typedef struct {
        rgbcs_pkg::chan_t    chan;
        logic [SUM_W-1:0]    total;
        logic [VAL_W-1:0]    minimum;
        logic [VAL_W-1:0]    maximum;
        logic [SQSUM_W-1:0]  sq_total;
        logic [PCOUNT_W-1:0] count;
        logic                overflow;
        logic                last;
    } channel_result_t;

    // DUT ports
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = rgbcs_pkg::REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // s_tdata from bit 0: red_value[16], green_value[16], blue_value[16]
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // m_tdata from bit 0: channel_total[40], channel_minimum[16],
    //   channel_maximum[16], squared_deviation_total[64], point_count[24],
    //   count_overflow[1], zero pad[7]
    logic [OUT_DATA_W-1:0] m_tdata;
    // m_tuser: channel[2]
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    // Stimulus and expectation stores
    point_t          points_to_send[$];
    channel_result_t pending_results[$];

    // Model copy of the config registers
    logic               mode_cfg;
    logic [MEAN_W-1:0]  mean_cfg [NCHAN];

    // Model copy of the statistics state
    logic               seed_pending;
    logic [SUM_W-1:0]   chan_sums [NCHAN];
    logic [VAL_W-1:0]   chan_mins [NCHAN];
    logic [VAL_W-1:0]   chan_maxs [NCHAN];
    logic [SQSUM_W-1:0] chan_sqsums [NCHAN];
    longint unsigned    points_seen;
    logic               overflow_seen;

    // Idling knobs, percent of cycles; owned by the sequencer
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_phase     = 1'b0;

    // Owned by the monitor; stuck_cycles by the watchdog
    int          error_count = 0;
    int          hold_left   = 0;
    logic        hold_done   = 1'b0;
    int          stuck_cycles = 0;

    point_t          next_point;
    channel_result_t exp_res;

    rgb_channel_statistics #(
        .COUNT_BITS (TB_COUNT_BITS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Statistics model: update state for one point, queue red/green/blue
    // ------------------------------------------------------------------------
    function automatic void accumulate_point(input logic [VAL_W-1:0] red,
                                             input logic [VAL_W-1:0] green,
                                             input logic [VAL_W-1:0] blue);
        logic [VAL_W-1:0]   vals [NCHAN];
        logic [VAL_W+MEAN_FRAC:0] scaled;
        logic [DEV_W-1:0]   dev;
        logic [SQ_W-1:0]    sq;
        channel_result_t    res;
        vals[0] = red;
        vals[1] = green;
        vals[2] = blue;
        for (int c = 0; c < NCHAN; c++) begin
            if (mode_cfg == rgbcs_pkg::MODE_TOTALS) begin
                if (seed_pending) begin
                    // first point seeds total, min and max
                    chan_sums[c] = SUM_W'(vals[c]);
                    chan_mins[c] = vals[c];
                    chan_maxs[c] = vals[c];
                end else begin
                    if (chan_sums[c] > TOTAL_MAX - SUM_W'(vals[c])) begin
                        chan_sums[c]  = TOTAL_MAX;
                        overflow_seen = 1'b1;
                    end else begin
                        chan_sums[c] = chan_sums[c] + SUM_W'(vals[c]);
                    end
                    // max only checked when the value is not a new min
                    if (vals[c] < chan_mins[c])
                        chan_mins[c] = vals[c];
                    else if (vals[c] > chan_maxs[c])
                        chan_maxs[c] = vals[c];
                end
            end else begin
                // |value.0 - mean| in 16.8, squared gives 2^-16 units
                scaled = {1'b0, vals[c], {MEAN_FRAC{1'b0}}};
                if (scaled >= {1'b0, mean_cfg[c]})
                    dev = DEV_W'(scaled - {1'b0, mean_cfg[c]});
                else
                    dev = DEV_W'({1'b0, mean_cfg[c]} - scaled);
                sq = SQ_W'(dev) * SQ_W'(dev);
                if (seed_pending) begin
                    chan_sqsums[c] = SQSUM_W'(sq);
                end else if (chan_sqsums[c] > SQ_MAX - SQSUM_W'(sq)) begin
                    chan_sqsums[c] = SQ_MAX;
                    overflow_seen  = 1'b1;
                end else begin
                    chan_sqsums[c] = chan_sqsums[c] + SQSUM_W'(sq);
                end
            end
        end
        seed_pending = 1'b0;

        if (points_seen >= COUNT_LIMIT) begin
            points_seen   = COUNT_LIMIT;
            overflow_seen = 1'b1;
        end else begin
            points_seen++;
        end

        for (int c = 0; c < NCHAN; c++) begin
            res.chan     = CHAN_CODE[c];
            res.total    = chan_sums[c];
            res.minimum  = chan_mins[c];
            res.maximum  = chan_maxs[c];
            res.sq_total = chan_sqsums[c];
            res.count    = PCOUNT_W'(points_seen);
            res.overflow = overflow_seen;
            res.last     = (c == NCHAN - 1);
            pending_results.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Driver: predicts on each accepted point, then offers the next one
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                accumulate_point(s_tdata[15:0], s_tdata[31:16], s_tdata[47:32]);
            if (!s_tvalid || s_tready) begin
                if (points_to_send.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    next_point = points_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {next_point.blue, next_point.green, next_point.red};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares each result request with the oldest expectation
    // ------------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] expv,
                               input logic [63:0] actv);
        if (expv !== actv) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, expv, actv);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got channel %0d",
                             $time, m_tuser);
                    error_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    check_field("channel",  64'(exp_res.chan),     64'(m_tuser));
                    check_field("total",    64'(exp_res.total),    64'(m_tdata[39:0]));
                    check_field("minimum",  64'(exp_res.minimum),  64'(m_tdata[55:40]));
                    check_field("maximum",  64'(exp_res.maximum),  64'(m_tdata[71:56]));
                    check_field("sq_total", exp_res.sq_total,      m_tdata[135:72]);
                    check_field("count",    64'(exp_res.count),    64'(m_tdata[159:136]));
                    check_field("overflow", 64'(exp_res.overflow), 64'(m_tdata[160]));
                    check_field("last",     64'(exp_res.last),     64'(m_tlast));
                end
            end
            // one long hold-off in the pressure phase, else random stalls
            if (hold_left != 0) begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (hold_phase && !hold_done) begin
                m_tready  <= 1'b0;
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: no request moving on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------------
    // Write all four registers back to back; only called while idle
    task automatic set_config(input logic mode, input logic [MEAN_W-1:0] red_mean,
                              input logic [MEAN_W-1:0] green_mean,
                              input logic [MEAN_W-1:0] blue_mean);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= rgbcs_pkg::REG_MODE;
        cfg_wdata <= CFG_DATA_W'(mode);
        @(posedge aclk);
        cfg_addr  <= rgbcs_pkg::REG_RED_MEAN;
        cfg_wdata <= red_mean;
        @(posedge aclk);
        cfg_addr  <= rgbcs_pkg::REG_GREEN_MEAN;
        cfg_wdata <= green_mean;
        @(posedge aclk);
        cfg_addr  <= rgbcs_pkg::REG_BLUE_MEAN;
        cfg_wdata <= blue_mean;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        mode_cfg    = mode;
        mean_cfg[0] = red_mean;
        mean_cfg[1] = green_mean;
        mean_cfg[2] = blue_mean;
    endtask

    task automatic push_point(input logic [VAL_W-1:0] red, input logic [VAL_W-1:0] green,
                              input logic [VAL_W-1:0] blue);
        point_t p;
        p.red   = red;
        p.green = green;
        p.blue  = blue;
        points_to_send.push_back(p);
    endtask

    // Wait until every point is taken and every result seen, plus latency
    task automatic drain();
        while (points_to_send.size() != 0 || s_tvalid || pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly full-range values, with extremes and small values mixed in
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return VAL_W'($urandom_range(0, 255));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [MEAN_W-1:0] random_mean();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            default: return MEAN_W'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned send_pct [4];
        int unsigned recv_pct [4];
        send_pct = '{0, 88, 0, 24};
        recv_pct = '{0, 0, 88, 24};

        mode_cfg      = rgbcs_pkg::MODE_TOTALS;
        mean_cfg      = '{default: '0};
        seed_pending  = 1'b1;
        chan_sums     = '{default: '0};
        chan_mins     = '{default: '0};
        chan_maxs     = '{default: '0};
        chan_sqsums   = '{default: '0};
        points_seen   = 0;
        overflow_seen = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Totals pass: first point seeds, then new min / new max / neither
        set_config(rgbcs_pkg::MODE_TOTALS, '0, '0, '0);
        push_point(16'h1234, 16'hFFFF, 16'h0000);
        push_point(16'h0000, 16'hFFFF, 16'hFFFF);
        push_point(16'hFFFF, 16'h0001, 16'h8000);
        push_point(16'h8000, 16'h8000, 16'h0000);
        push_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_point(16'h0000, 16'h0000, 16'h0000);
        push_point(16'h5555, 16'hAAAA, 16'h00FF);
        push_point(16'hAAAA, 16'h5555, 16'hFF00);
        drain();

        // Deviation pass: zero deviation, mean at both ends, fractional mean
        set_config(rgbcs_pkg::MODE_DEVIATION, 24'h000000, 24'hFFFFFF, 24'h123480);
        push_point(16'h0000, 16'h0000, 16'h0000);
        push_point(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_point(16'h0000, 16'h8000, 16'h1234);
        push_point(16'h1235, 16'h0001, 16'h1235);
        push_point(16'hFFFF, 16'h0000, 16'h1234);
        drain();

        set_config(rgbcs_pkg::MODE_DEVIATION, 24'hFFFFFF, 24'h000080, 24'h000000);
        push_point(16'h0000, 16'h0000, 16'hFFFF);
        push_point(16'hFFFF, 16'h0001, 16'h0000);
        push_point(16'h7FFF, 16'h0000, 16'h8000);
        drain();

        // Back to totals: state carries on from the first pass
        set_config(rgbcs_pkg::MODE_TOTALS, 24'h800000, 24'h000001, 24'hFFFFFF);
        push_point(16'h0001, 16'hFFFE, 16'h7FFF);
        push_point(16'hFFFF, 16'h0000, 16'h8001);
        drain();

        // Random phases, one per idling pattern, alternating the pass
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = send_pct[p];
            recv_stall_pct = recv_pct[p];
            set_config((p % 2 == 0) ? rgbcs_pkg::MODE_TOTALS : rgbcs_pkg::MODE_DEVIATION,
                       random_mean(), random_mean(), random_mean());
            for (int i = 0; i < RANDOM_ITEMS; i++)
                push_point(random_value(), random_value(), random_value());
            drain();
        end

        // Pressure: receiver holds off while the sender keeps offering
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config($urandom_range(0, 1) ? rgbcs_pkg::MODE_DEVIATION : rgbcs_pkg::MODE_TOTALS,
                   random_mean(), random_mean(), random_mean());
        hold_phase = 1'b1;
        for (int i = 0; i < 24; i++)
            push_point(random_value(), random_value(), random_value());
        drain();
        hold_phase = 1'b0;

        // A few more totals on the carried state
        set_config(rgbcs_pkg::MODE_TOTALS, '0, '0, '0);
        for (int i = 0; i < 4; i++)
            push_point(random_value(), random_value(), random_value());
        drain();

        // Any stray result would show up here
        repeat (4 * DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
